@@ hw/rtl/dwr_pkg.sv @@
// Shared types and constants for the detection world registration block.
// Used by the interfaces, the controller, the datapath and the top level.
package dwr_pkg;

  // Fixed field widths
  localparam int unsigned TOTAL_W    = 4;
  localparam int unsigned RANGE_W    = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned DEN_W      = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SURV    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_PX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_KNOWN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd3;

  // Arithmetic constants
  localparam logic [17:0]        INV_TAN_HALF_FOV = 18'd95355;  // 1/tan(34.5 deg), Q16
  localparam logic [RANGE_W-1:0] RANGE_MIN        = 20'd32768;  // 0.5 m
  localparam logic [RANGE_W-1:0] RANGE_MAX        = 20'd655360; // 10 m
  localparam logic [12:0]        RANGE_NUM_SCALE  = 13'd4352;   // 1.7 * 10 * 256
  localparam logic [3:0]         RANGE_DEN_SCALE  = 4'd10;
  localparam logic signed [15:0] ONE_Q14          = 16'sd16384;

  // Controller states
  typedef enum logic [5:0] {
    S_IDLE, S_CHECK, S_MUL_FOC, S_SET_FOC, S_DIV_RNG, S_WAIT_RNG, S_SET_RNG,
    S_MUL_LAT, S_DIV_LAT, S_WAIT_LAT, S_SET_LAT, S_MUL_WZ, S_MUL_XY, S_MUL_YY,
    S_MUL_ZZ, S_SET_C, S_NORM, S_SQ_S, S_SQ_C, S_SQRT, S_WAIT_SQRT, S_DIV_CS,
    S_WAIT_CS, S_SET_CS, S_DIV_SN, S_WAIT_SN, S_SET_SN, S_MUL_RC, S_MUL_LS,
    S_MUL_RS, S_MUL_LC, S_SUM_Y, S_WORLD, S_WALK_INIT, S_WALK_RD, S_WALK_CMP,
    S_STORE, S_FINISH
  } dwr_state_t;

  // Datapath commands
  typedef enum logic [5:0] {
    C_NOP, C_LOAD, C_MUL_FOC, C_SET_FOC, C_DIV_RNG, C_SET_RNG, C_MUL_LAT,
    C_DIV_LAT, C_SET_LAT, C_MUL_WZ, C_MUL_XY, C_MUL_YY, C_MUL_ZZ, C_SET_C,
    C_NORM, C_SQ_S, C_SQ_C, C_SQRT, C_DIV_CS, C_SET_CS, C_DIV_SN, C_SET_SN,
    C_MUL_RC, C_MUL_LS, C_MUL_RS, C_MUL_LC, C_SUM_Y, C_WORLD, C_WALK_INIT,
    C_RD, C_CMP, C_STORE, C_PUSH
  } dwr_cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic pose_ok;
    logic div_done;
    logic sqrt_done;
    logic walk_more;
  } dwr_stat_t;

endpackage

@@ hw/rtl/dwr_if.sv @@
// Handshake interfaces for detection items and result items.
// Depends on dwr_pkg for the fixed result widths.
interface dwr_det_if #(parameter int PIXEL_BITS = 12) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] box_left;
  logic [PIXEL_BITS-1:0] box_width;
  logic [PIXEL_BITS-1:0] box_height;
  logic signed [31:0]    robot_x;
  logic signed [31:0]    robot_y;
  logic signed [15:0]    quat_w;
  logic signed [15:0]    quat_x;
  logic signed [15:0]    quat_y;
  logic signed [15:0]    quat_z;
  logic                  pose_valid;

  modport source (output valid, box_left, box_width, box_height, robot_x, robot_y,
                  quat_w, quat_x, quat_y, quat_z, pose_valid, input ready);
  modport sink (input valid, box_left, box_width, box_height, robot_x, robot_y,
                quat_w, quat_x, quat_y, quat_z, pose_valid, output ready);
endinterface

interface dwr_res_if ();
  logic                                 valid;
  logic                                 ready;
  logic                                 stored;
  logic signed [31:0]                   world_x;
  logic signed [31:0]                   world_y;
  logic [dwr_pkg::RANGE_W-1:0]          range_m;
  logic [dwr_pkg::TOTAL_W-1:0]          survivor_total;

  modport source (output valid, stored, world_x, world_y, range_m, survivor_total,
                  input ready);
  modport sink (input valid, stored, world_x, world_y, range_m, survivor_total,
                output ready);
endinterface

@@ hw/rtl/dwr_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; shared by all quotients of the datapath.
module dwr_div #(
  parameter int NW = 45,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem, quo[NW-1]};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift quotient bits in, hold remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
      cnt   <= CW'(NW);
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo <= {quo[NW-2:0], ge};
      cnt <= cnt - CW'(1);
    end
  end

endmodule

@@ hw/rtl/dwr_sqrt.sv @@
// Serial integer square root, one result bit per cycle over a 64-bit radicand.
// Standalone; used for the quaternion yaw norm.
module dwr_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        done
);
  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [63:0] rb;
  logic        busy;

  assign rb   = r + bitv;
  assign root = r[31:0];

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Digit-by-digit root, two radicand bits a step
  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      r    <= '0;
      bitv <= 64'd1 << 62;
    end else if (busy) begin
      if (v >= rb) begin
        v <= v - rb;
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

@@ hw/rtl/dwr_ctrl.sv @@
// Sequencer of the registration datapath and owner of the handshakes.
// Depends on dwr_pkg for states, commands and status.
module dwr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  dwr_pkg::dwr_stat_t st,
  output dwr_pkg::dwr_cmd_t  cmd
);
  dwr_pkg::dwr_state_t state, state_next;
  logic                push;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dwr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid: set on push, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = dwr_pkg::C_NOP;
    in_ready   = 1'b0;
    push       = 1'b0;
    unique case (state)
      dwr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = dwr_pkg::C_LOAD;
          state_next = dwr_pkg::S_CHECK;
        end
      end
      dwr_pkg::S_CHECK:
        state_next = st.pose_ok ? dwr_pkg::S_MUL_FOC : dwr_pkg::S_FINISH;
      dwr_pkg::S_MUL_FOC: begin
        cmd = dwr_pkg::C_MUL_FOC; state_next = dwr_pkg::S_SET_FOC;
      end
      dwr_pkg::S_SET_FOC: begin
        cmd = dwr_pkg::C_SET_FOC; state_next = dwr_pkg::S_DIV_RNG;
      end
      dwr_pkg::S_DIV_RNG: begin
        cmd = dwr_pkg::C_DIV_RNG; state_next = dwr_pkg::S_WAIT_RNG;
      end
      dwr_pkg::S_WAIT_RNG:
        if (st.div_done) state_next = dwr_pkg::S_SET_RNG;
      dwr_pkg::S_SET_RNG: begin
        cmd = dwr_pkg::C_SET_RNG; state_next = dwr_pkg::S_MUL_LAT;
      end
      dwr_pkg::S_MUL_LAT: begin
        cmd = dwr_pkg::C_MUL_LAT; state_next = dwr_pkg::S_DIV_LAT;
      end
      dwr_pkg::S_DIV_LAT: begin
        cmd = dwr_pkg::C_DIV_LAT; state_next = dwr_pkg::S_WAIT_LAT;
      end
      dwr_pkg::S_WAIT_LAT:
        if (st.div_done) state_next = dwr_pkg::S_SET_LAT;
      dwr_pkg::S_SET_LAT: begin
        cmd = dwr_pkg::C_SET_LAT; state_next = dwr_pkg::S_MUL_WZ;
      end
      dwr_pkg::S_MUL_WZ: begin
        cmd = dwr_pkg::C_MUL_WZ; state_next = dwr_pkg::S_MUL_XY;
      end
      dwr_pkg::S_MUL_XY: begin
        cmd = dwr_pkg::C_MUL_XY; state_next = dwr_pkg::S_MUL_YY;
      end
      dwr_pkg::S_MUL_YY: begin
        cmd = dwr_pkg::C_MUL_YY; state_next = dwr_pkg::S_MUL_ZZ;
      end
      dwr_pkg::S_MUL_ZZ: begin
        cmd = dwr_pkg::C_MUL_ZZ; state_next = dwr_pkg::S_SET_C;
      end
      dwr_pkg::S_SET_C: begin
        cmd = dwr_pkg::C_SET_C; state_next = dwr_pkg::S_NORM;
      end
      dwr_pkg::S_NORM: begin
        cmd = dwr_pkg::C_NORM; state_next = dwr_pkg::S_SQ_S;
      end
      dwr_pkg::S_SQ_S: begin
        cmd = dwr_pkg::C_SQ_S; state_next = dwr_pkg::S_SQ_C;
      end
      dwr_pkg::S_SQ_C: begin
        cmd = dwr_pkg::C_SQ_C; state_next = dwr_pkg::S_SQRT;
      end
      dwr_pkg::S_SQRT: begin
        cmd = dwr_pkg::C_SQRT; state_next = dwr_pkg::S_WAIT_SQRT;
      end
      dwr_pkg::S_WAIT_SQRT:
        if (st.sqrt_done) state_next = dwr_pkg::S_DIV_CS;
      dwr_pkg::S_DIV_CS: begin
        cmd = dwr_pkg::C_DIV_CS; state_next = dwr_pkg::S_WAIT_CS;
      end
      dwr_pkg::S_WAIT_CS:
        if (st.div_done) state_next = dwr_pkg::S_SET_CS;
      dwr_pkg::S_SET_CS: begin
        cmd = dwr_pkg::C_SET_CS; state_next = dwr_pkg::S_DIV_SN;
      end
      dwr_pkg::S_DIV_SN: begin
        cmd = dwr_pkg::C_DIV_SN; state_next = dwr_pkg::S_WAIT_SN;
      end
      dwr_pkg::S_WAIT_SN:
        if (st.div_done) state_next = dwr_pkg::S_SET_SN;
      dwr_pkg::S_SET_SN: begin
        cmd = dwr_pkg::C_SET_SN; state_next = dwr_pkg::S_MUL_RC;
      end
      dwr_pkg::S_MUL_RC: begin
        cmd = dwr_pkg::C_MUL_RC; state_next = dwr_pkg::S_MUL_LS;
      end
      dwr_pkg::S_MUL_LS: begin
        cmd = dwr_pkg::C_MUL_LS; state_next = dwr_pkg::S_MUL_RS;
      end
      dwr_pkg::S_MUL_RS: begin
        cmd = dwr_pkg::C_MUL_RS; state_next = dwr_pkg::S_MUL_LC;
      end
      dwr_pkg::S_MUL_LC: begin
        cmd = dwr_pkg::C_MUL_LC; state_next = dwr_pkg::S_SUM_Y;
      end
      dwr_pkg::S_SUM_Y: begin
        cmd = dwr_pkg::C_SUM_Y; state_next = dwr_pkg::S_WORLD;
      end
      dwr_pkg::S_WORLD: begin
        cmd = dwr_pkg::C_WORLD; state_next = dwr_pkg::S_WALK_INIT;
      end
      dwr_pkg::S_WALK_INIT: begin
        cmd = dwr_pkg::C_WALK_INIT; state_next = dwr_pkg::S_WALK_RD;
      end
      dwr_pkg::S_WALK_RD: begin
        if (st.walk_more) begin
          cmd = dwr_pkg::C_RD; state_next = dwr_pkg::S_WALK_CMP;
        end else begin
          state_next = dwr_pkg::S_STORE;
        end
      end
      dwr_pkg::S_WALK_CMP: begin
        cmd = dwr_pkg::C_CMP; state_next = dwr_pkg::S_WALK_RD;
      end
      dwr_pkg::S_STORE: begin
        cmd = dwr_pkg::C_STORE; state_next = dwr_pkg::S_FINISH;
      end
      dwr_pkg::S_FINISH: begin
        // Wait for the result register to free up
        if (!out_valid || out_ready) begin
          cmd        = dwr_pkg::C_PUSH;
          push       = 1'b1;
          state_next = dwr_pkg::S_IDLE;
        end
      end
      default: state_next = dwr_pkg::S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/dwr_dpath.sv @@
// Registration datapath: config registers, shared multiplier, divider, root unit,
// point store and result register. Depends on dwr_pkg, dwr_div, dwr_sqrt.
module dwr_dpath #(
  parameter int STORE_DEPTH = 8,
  parameter int PIXEL_BITS  = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dwr_pkg::dwr_cmd_t                 cmd,
  output dwr_pkg::dwr_stat_t                st,
  input  logic                              cfg_we,
  input  logic [dwr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dwr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [PIXEL_BITS-1:0]             box_left,
  input  logic [PIXEL_BITS-1:0]             box_width,
  input  logic [PIXEL_BITS-1:0]             box_height,
  input  logic signed [31:0]                robot_x,
  input  logic signed [31:0]                robot_y,
  input  logic signed [15:0]                quat_w,
  input  logic signed [15:0]                quat_x,
  input  logic signed [15:0]                quat_y,
  input  logic signed [15:0]                quat_z,
  input  logic                              pose_valid,
  output logic                              stored,
  output logic signed [31:0]                world_x,
  output logic signed [31:0]                world_y,
  output logic [dwr_pkg::RANGE_W-1:0]       range_m,
  output logic [dwr_pkg::TOTAL_W-1:0]       survivor_total
);
  localparam int CW   = $clog2(STORE_DEPTH + 1);
  localparam int AIW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LIMW = (CW > 4) ? CW : 4;
  localparam int DW   = ((PIXEL_BITS + 1 > 12) ? PIXEL_BITS + 1 : 12) + 1;
  localparam int LW   = DW + 28;
  localparam int PW   = LW + 18;
  localparam int NW   = (LW - 1 > 45) ? LW - 1 : 45;
  localparam logic signed [PW-1:0] S32_MAX = PW'(64'sh7FFF_FFFF);
  localparam logic signed [PW-1:0] S32_MIN = PW'(-64'sh8000_0000);

  // Configuration
  logic [3:0]  max_surv;
  logic [23:0] focal_px;
  logic        focal_known;
  logic [11:0] image_width;

  // Item operands
  logic [PIXEL_BITS-1:0] bl, bw, bh;
  logic signed [31:0]    rx, ry;
  logic signed [15:0]    qw, qx, qy, qz;
  logic                  pose_ok;

  // Working registers
  logic [23:0]           focal;
  logic [19:0]           rng;
  logic signed [PW-1:0]  prod;
  logic                  lat_neg;
  logic signed [LW-1:0]  lat;
  logic signed [34:0]    s, c;
  logic                  s_neg, c_neg;
  logic [30:0]           ms, mc;
  logic [61:0]           sq_s, sq_c;
  logic signed [15:0]    cs, sn;
  logic signed [PW-1:0]  tx, ty;
  logic signed [31:0]    wx, wy;
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic                  near;
  logic                  did_store;
  logic signed [31:0]    rd_x, rd_y;

  // Point store
  logic signed [31:0] mem_x [STORE_DEPTH];
  logic signed [31:0] mem_y [STORE_DEPTH];

  // Shared units
  logic                  div_start;
  logic [NW-1:0]         div_num;
  logic [dwr_pkg::DEN_W-1:0] div_den;
  logic [NW-1:0]         quo;
  logic                  div_done;
  logic                  sqrt_done;
  logic [31:0]           root;

  // Combinational helpers
  logic [10:0]            half;
  logic signed [DW-1:0]   diff;
  logic signed [LW-1:0]   ma;
  logic signed [17:0]     mb;
  logic signed [PW-1:0]   mul;
  logic [PW-1:0]          prod_mag;
  logic [30:0]            sq_op;
  logic [61:0]            sq;
  logic [34:0]            ms_full, mc_full, or_full;
  logic [19:0]            rng_q;
  logic [15:0]            trig_q;
  logic signed [PW-1:0]   tq_x, tq_y;
  logic signed [32:0]     dx, dy;
  logic [32:0]            adx, ady;
  logic [32:0]            dsq;
  logic                   hit;
  logic [LIMW-1:0]        lim;
  logic                   room;

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7FFF_FFFF;
    else if (v < S32_MIN) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [PW-1:0] div_q14(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] a;
    a = v + (v[PW-1] ? PW'(16383) : PW'(0));
    return a >>> 14;
  endfunction

  dwr_div #(.NW(NW), .DW(dwr_pkg::DEN_W)) u_div (
    .clk (clk), .rst (rst), .start (div_start), .num (div_num), .den (div_den),
    .quo (quo), .done (div_done)
  );

  dwr_sqrt u_sqrt (
    .clk (clk), .rst (rst), .start (cmd == dwr_pkg::C_SQRT),
    .radicand (64'(sq_s) + 64'(sq_c)), .root (root), .done (sqrt_done)
  );

  // Status
  always_comb begin
    st.pose_ok   = pose_ok;
    st.div_done  = div_done;
    st.sqrt_done = sqrt_done;
    st.walk_more = idx < count;
  end

  // Geometry helpers
  always_comb begin
    half     = image_width[11:1];
    diff     = $signed(DW'(bl) + DW'(bw >> 1)) - $signed(DW'(half));
    prod_mag = prod[PW-1] ? PW'(-prod) : PW'(prod);
    ms_full  = s[34] ? 35'(-s) : 35'(s);
    mc_full  = c[34] ? 35'(-c) : 35'(c);
    or_full  = ms_full | mc_full;
    rng_q    = (quo > NW'(dwr_pkg::RANGE_MAX)) ? dwr_pkg::RANGE_MAX :
               (quo < NW'(dwr_pkg::RANGE_MIN)) ? dwr_pkg::RANGE_MIN : quo[19:0];
    trig_q   = quo[15:0];
    tq_x     = div_q14(tx);
    tq_y     = div_q14(ty);
    lim      = (LIMW'(max_surv) < LIMW'(STORE_DEPTH)) ? LIMW'(max_surv)
                                                     : LIMW'(STORE_DEPTH);
    room     = LIMW'(count) < lim;
  end

  // Shared multiplier operand select
  always_comb begin
    case (cmd)
      dwr_pkg::C_MUL_FOC: begin
        ma = LW'(half); mb = dwr_pkg::INV_TAN_HALF_FOV;
      end
      dwr_pkg::C_MUL_LAT: begin ma = LW'(rng); mb = 18'(diff); end
      dwr_pkg::C_MUL_WZ:  begin ma = LW'(qw);  mb = 18'(qz);   end
      dwr_pkg::C_MUL_XY:  begin ma = LW'(qx);  mb = 18'(qy);   end
      dwr_pkg::C_MUL_YY:  begin ma = LW'(qy);  mb = 18'(qy);   end
      dwr_pkg::C_MUL_ZZ:  begin ma = LW'(qz);  mb = 18'(qz);   end
      dwr_pkg::C_MUL_RC:  begin ma = LW'(rng); mb = 18'(cs);   end
      dwr_pkg::C_MUL_LS:  begin ma = lat;      mb = 18'(sn);   end
      dwr_pkg::C_MUL_RS:  begin ma = LW'(rng); mb = 18'(sn);   end
      dwr_pkg::C_MUL_LC:  begin ma = lat;      mb = 18'(cs);   end
      default:            begin ma = '0;       mb = '0;        end
    endcase
    mul = PW'(ma) * PW'(mb);
  end

  // Divider operand select
  always_comb begin
    div_start = 1'b1;
    case (cmd)
      dwr_pkg::C_DIV_RNG: begin
        div_num = NW'(focal) * NW'(dwr_pkg::RANGE_NUM_SCALE);
        div_den = dwr_pkg::DEN_W'(bh) * dwr_pkg::DEN_W'(dwr_pkg::RANGE_DEN_SCALE);
      end
      dwr_pkg::C_DIV_LAT: begin
        div_num = NW'({prod_mag, 8'd0});
        div_den = dwr_pkg::DEN_W'(focal);
      end
      dwr_pkg::C_DIV_CS: begin
        div_num = NW'({mc, 14'd0});
        div_den = root;
      end
      dwr_pkg::C_DIV_SN: begin
        div_num = NW'({ms, 14'd0});
        div_den = root;
      end
      default: begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
      end
    endcase
  end

  // Squarer for the yaw norm
  assign sq_op = (cmd == dwr_pkg::C_SQ_C) ? mc : ms;
  assign sq    = sq_op * sq_op;

  // Near test against the stored point just read
  always_comb begin
    dx  = 33'(rd_x) - 33'(wx);
    dy  = 33'(rd_y) - 33'(wy);
    adx = dx[32] ? 33'(-dx) : 33'(dx);
    ady = dy[32] ? 33'(-dy) : 33'(dy);
    dsq = 33'(adx[15:0] * adx[15:0]) + 33'(ady[15:0] * ady[15:0]);
    hit = (adx[32:16] == '0) && (ady[32:16] == '0) && !dsq[32];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_surv    <= 4'd6;
      focal_px    <= '0;
      focal_known <= 1'b0;
      image_width <= 12'd640;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dwr_pkg::REG_MAX_SURV:    max_surv    <= cfg_data[3:0];
        dwr_pkg::REG_FOCAL_PX:    focal_px    <= cfg_data;
        dwr_pkg::REG_FOCAL_KNOWN: focal_known <= cfg_data[0];
        dwr_pkg::REG_IMAGE_WIDTH: image_width <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Stored point count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd == dwr_pkg::C_STORE && !near && room) begin
      count <= count + CW'(1);
    end
  end

  // Point store write and registered read
  always_ff @(posedge clk) begin
    if (cmd == dwr_pkg::C_STORE && !near && room) begin
      mem_x[count[AIW-1:0]] <= wx;
      mem_y[count[AIW-1:0]] <= wy;
    end
    if (cmd == dwr_pkg::C_RD) begin
      rd_x <= mem_x[idx[AIW-1:0]];
      rd_y <= mem_y[idx[AIW-1:0]];
    end
  end

  // Item working registers
  always_ff @(posedge clk) begin
    case (cmd)
      dwr_pkg::C_LOAD: begin
        bl <= box_left; bw <= box_width; bh <= box_height;
        rx <= robot_x;  ry <= robot_y;
        qw <= quat_w; qx <= quat_x; qy <= quat_y; qz <= quat_z;
        pose_ok   <= pose_valid;
        did_store <= 1'b0;
      end
      dwr_pkg::C_MUL_FOC: prod <= mul;
      dwr_pkg::C_SET_FOC: focal <= focal_known ? focal_px : 24'((prod + PW'(128)) >>> 8);
      dwr_pkg::C_SET_RNG: rng <= (bh == '0) ? dwr_pkg::RANGE_MAX : rng_q;
      dwr_pkg::C_MUL_LAT: prod <= mul;
      dwr_pkg::C_DIV_LAT: lat_neg <= prod[PW-1];
      dwr_pkg::C_SET_LAT: begin
        if (focal == '0) lat <= '0;
        else lat <= lat_neg ? LW'(-$signed({1'b0, quo})) : LW'(quo);
      end
      dwr_pkg::C_MUL_WZ: prod <= mul;
      dwr_pkg::C_MUL_XY: begin s <= 35'(prod); prod <= mul; end
      dwr_pkg::C_MUL_YY: begin s <= 35'((s + 35'(prod)) <<< 1); prod <= mul; end
      dwr_pkg::C_MUL_ZZ: begin c <= 35'(prod); prod <= mul; end
      dwr_pkg::C_SET_C:  c <= 35'sd268435456 - 35'((c + 35'(prod)) <<< 1);
      dwr_pkg::C_NORM: begin
        // Scale both by one shift: two bits if either reaches 2^32, one if 2^31
        s_neg <= s[34];
        c_neg <= c[34];
        if (|or_full[34:32]) begin
          ms <= 31'(ms_full >> 2); mc <= 31'(mc_full >> 2);
        end else if (or_full[31]) begin
          ms <= 31'(ms_full >> 1); mc <= 31'(mc_full >> 1);
        end else begin
          ms <= 31'(ms_full); mc <= 31'(mc_full);
        end
      end
      dwr_pkg::C_SQ_S: sq_s <= sq;
      dwr_pkg::C_SQ_C: sq_c <= sq;
      dwr_pkg::C_SET_CS: begin
        if (root == '0) cs <= dwr_pkg::ONE_Q14;
        else cs <= c_neg ? -$signed(trig_q) : $signed(trig_q);
      end
      dwr_pkg::C_SET_SN: begin
        if (root == '0) sn <= '0;
        else sn <= s_neg ? -$signed(trig_q) : $signed(trig_q);
      end
      dwr_pkg::C_MUL_RC: prod <= mul;
      dwr_pkg::C_MUL_LS: begin tx <= prod; prod <= mul; end
      dwr_pkg::C_MUL_RS: begin tx <= tx - prod; prod <= mul; end
      dwr_pkg::C_MUL_LC: begin ty <= prod; prod <= mul; end
      dwr_pkg::C_SUM_Y:  ty <= ty + prod;
      dwr_pkg::C_WORLD: begin
        wx <= sat32(PW'(rx) + tq_x);
        wy <= sat32(PW'(ry) + tq_y);
      end
      dwr_pkg::C_WALK_INIT: begin idx <= '0; near <= 1'b0; end
      dwr_pkg::C_CMP: begin near <= near | hit; idx <= idx + CW'(1); end
      dwr_pkg::C_STORE: if (!near && room) did_store <= 1'b1;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd == dwr_pkg::C_PUSH) begin
      stored         <= pose_ok & did_store;
      world_x        <= pose_ok ? wx : '0;
      world_y        <= pose_ok ? wy : '0;
      range_m        <= pose_ok ? rng : '0;
      survivor_total <= dwr_pkg::TOTAL_W'(count);
    end
  end

endmodule

@@ hw/rtl/detection_world_registration.sv @@
// Top level of the detection world registration block.
// Depends on dwr_pkg, dwr_if, dwr_ctrl and dwr_dpath.
//
// Usage:
//   det carries one person box plus the robot pose per item; res returns one
//   result item per detection: stored flag, world x/y, range and point total.
//   Both channels use valid/ready; an item moves when both are high.
//   Registers are written through cfg_we/cfg_index/cfg_data only while idle;
//   the user must keep to this, as the block itself does not enforce it.
// Sequence:
//   With an invalid pose the arithmetic is skipped and the result is pushed
//   directly. With a valid pose the bit-serial divider runs once each for range,
//   lateral offset, cosine and sine, and the root unit once for the yaw norm;
//   each stored point is then read and compared. One item is worked on at a time.
// Reset:
//   rst (synchronous, active high) empties the point store and restores the
//   register defaults. Stored coordinates need no clearing.
// Stalls:
//   A finished result waits in the output register; the next item is taken
//   meanwhile and its result holds until the previous one is taken.
module detection_world_registration #(
  parameter int STORE_DEPTH = 8,
  parameter int PIXEL_BITS  = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  dwr_det_if.sink                        det,
  dwr_res_if.source                      res,
  input  logic                           cfg_we,
  input  logic [dwr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dwr_pkg::CFG_DATA_W-1:0] cfg_data
);
  dwr_pkg::dwr_cmd_t  cmd;
  dwr_pkg::dwr_stat_t st;

  // Sequencer
  dwr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (det.valid),
    .in_ready  (det.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Arithmetic and storage
  dwr_dpath #(.STORE_DEPTH(STORE_DEPTH), .PIXEL_BITS(PIXEL_BITS)) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .box_left       (det.box_left),
    .box_width      (det.box_width),
    .box_height     (det.box_height),
    .robot_x        (det.robot_x),
    .robot_y        (det.robot_y),
    .quat_w         (det.quat_w),
    .quat_x         (det.quat_x),
    .quat_y         (det.quat_y),
    .quat_z         (det.quat_z),
    .pose_valid     (det.pose_valid),
    .stored         (res.stored),
    .world_x        (res.world_x),
    .world_y        (res.world_y),
    .range_m        (res.range_m),
    .survivor_total (res.survivor_total)
  );

endmodule
